FILE: hw/rtl/soc_pkg.sv
package soc_pkg;

    localparam int MAX_OBJECTS_DEF  = 256;
    localparam int MAX_VERTICES_DEF = 64;

    localparam int COORD_W  = 15;
    localparam int CNT_W    = 6;
    localparam int OBJCNT_W = 9;
    localparam int HITS_W   = 14;

    localparam int NEAR_SPAN    = 2;
    localparam int PARALLEL_EPS = 328;
    localparam int FAR_START    = 32766;
    localparam int Q_SHIFT      = 16;

    localparam int DIV_NUM_W = 62;
    localparam int DIV_DEN_W = 32;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  object_index;
        logic [5:0]  vertex_index;
        logic [5:0]  segment_count;
        logic [14:0] vertex_x;
        logic [14:0] vertex_y;
        logic [14:0] start_x;
        logic [14:0] start_y;
        logic [14:0] end_x;
        logic [14:0] end_y;
    } t_req;

    typedef struct packed {
        logic signed [8:0]  hit_object;
        logic [13:0]        hit_count;
        logic signed [15:0] first_hit_x;
        logic signed [15:0] first_hit_y;
    } t_rsp;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

FILE: hw/rtl/soc_ram.sv
module soc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/soc_div.sv
module soc_div import soc_pkg::*; #(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = DIV_DEN_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_sts         o_sts,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] diff;

    assign shifted = {r_rem, r_quo[NUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            if (!diff[DEN_W+1]) begin
                r_rem <= diff[DEN_W-1:0];
            end else begin
                r_rem <= shifted[DEN_W-1:0];
            end
            r_quo <= {r_quo[NUM_W-2:0], ~diff[DEN_W+1]};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo      = r_quo;

endmodule

FILE: hw/rtl/segment_obstacle_collision_scan.sv
// Obstacle map crossing scan.
// Request channel (i_req_valid / o_req_ready, payload i_req): a load item writes
// one map vertex and the edge count of its object when accepted and gives no
// result. A query item scans edges of objects 0 .. object_count-1 and gives one
// result item on o_rsp_valid / i_rsp_ready (payload o_rsp).
// Configuration: i_cfg_we with i_cfg_wdata writes object_count at once.
// Flow: a query is accepted, then the divider sets up its slope unless the
// query is near-vertical; per object the edge count is read and the edges are
// walked, each edge taking the no-overlap, near-vertical-edge, near-parallel,
// near-vertical-query or general-crossing path (a first crossing found on the
// general path also computes its y), and the result is posted at the end. The
// single shared restoring divider serves the query slope, the edge slope and
// the crossing x, and the map memory gives one read per cycle.
// Ready is high only while the sequencer is idle; a load leaves it idle.
// The result sits in an output register; a new item is taken while it waits,
// and a finishing query holds until the receiver has taken the previous result.
// Reset clears object_count and the sequencer; map memories are not cleared.
module segment_obstacle_collision_scan import soc_pkg::*; #(
    parameter int MAX_OBJECTS  = MAX_OBJECTS_DEF,
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  t_req                i_req,
    output logic                o_rsp_valid,
    input  logic                i_rsp_ready,
    output t_rsp                o_rsp,
    input  logic                i_cfg_we,
    input  logic [OBJCNT_W-1:0] i_cfg_wdata
);

    localparam int OBJ_AW  = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int VDEPTH  = MAX_OBJECTS * MAX_VERTICES;
    localparam int VADDR_W = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES - 1);
    localparam logic signed [8:0] K_NONE = -9'sd1;

    typedef enum logic [24:0] {
        S_IDLE  = 25'h0000001,
        S_QDIV  = 25'h0000002,
        S_QMUL  = 25'h0000004,
        S_QB    = 25'h0000008,
        S_OBJ   = 25'h0000010,
        S_CNT   = 25'h0000020,
        S_EDGE  = 25'h0000040,
        S_RD0   = 25'h0000080,
        S_RD1   = 25'h0000100,
        S_CLASS = 25'h0000200,
        S_VPY   = 25'h0000400,
        S_VCHK  = 25'h0000800,
        S_EDIV  = 25'h0001000,
        S_EMUL  = 25'h0002000,
        S_EB    = 25'h0004000,
        S_GSEL  = 25'h0008000,
        S_QPY   = 25'h0010000,
        S_QCHK  = 25'h0020000,
        S_PDIV  = 25'h0040000,
        S_PCHK  = 25'h0080000,
        S_HY1   = 25'h0100000,
        S_HY2   = 25'h0200000,
        S_HY3   = 25'h0400000,
        S_NEXT  = 25'h0800000,
        S_DONE  = 25'h1000000
    } t_state;

    t_state r_state, n_state;

    logic [OBJCNT_W-1:0] r_object_count;
    logic [OBJCNT_W-1:0] nobj;

    logic [COORD_W-1:0] r_xs, r_ys, r_x1, r_x2, r_y1, r_hy1, r_hy2;
    logic               r_qgen;
    logic signed [31:0] r_atmp, r_a;
    logic signed [47:0] r_btmp, r_b;
    logic [OBJCNT_W-1:0] r_n;
    logic [CNT_W-1:0]   r_m, r_cnt;
    logic [COORD_W-1:0] r_vx0, r_vy0;
    logic [COORD_W-1:0] r_xc1, r_yc1, r_xc2, r_yc2, r_hym1, r_hym2;
    logic signed [63:0] r_px;
    logic signed [49:0] r_py;
    logic signed [63:0] r_prod;
    logic               r_div_neg, n_div_neg;
    logic [COORD_W-1:0] r_minpx, r_minpy;
    logic signed [8:0]  r_k;
    logic [HITS_W-1:0]  r_hits;
    logic               r_have_first;
    logic signed [15:0] r_hx, r_hy;
    t_rsp               r_rsp;
    logic               r_rsp_valid;

    // query setup
    logic               req_acc, q_swap, q_gen, q_neg;
    logic [COORD_W-1:0] q_x1, q_y1, q_x2, q_y2, q_dx, q_dy;

    // map memories
    logic                  load_we;
    logic [VADDR_W-1:0]    v_waddr, v_base, v_raddr;
    logic [2*COORD_W-1:0]  v_rdata;
    logic [CNT_W-1:0]      c_rdata;

    // edge sort
    logic [COORD_W-1:0] e_xb, e_yb;
    logic               ovl, nv_edge, e_neg;
    logic [COORD_W-1:0] e_dy;

    // general case
    logic signed [32:0] da;
    logic signed [48:0] db;
    logic [32:0]        da_mag;
    logic [48:0]        db_mag;
    logic               nonpar;

    // shared divider and multiplier
    t_div_cmd           div_cmd;
    t_div_sts           div_sts;
    logic [DIV_NUM_W-1:0] div_quo;
    logic signed [63:0] div_q;
    logic signed [31:0] mul_a, mul_b;

    // crossing checks
    logic               chk_hit, chk_take_x, chk_take_y;
    logic [COORD_W-1:0] chk_minpx, chk_minpy;
    logic signed [15:0] chk_hx, chk_hy;
    logic [COORD_W-1:0] dvx;
    logic signed [49:0] pyd;
    logic [49:0]        pyd_mag;
    logic signed [63:0] pxd, px_hi, px_rnd;
    logic [63:0]        pxd_mag;
    logic signed [63:0] t1;
    logic signed [49:0] s_q;

    function automatic logic signed [63:0] trunc_q16(input logic signed [63:0] v);
        logic signed [63:0] adj;
        adj = v + ((v < 0) ? 64'sd65535 : 64'sd0);
        return adj >>> Q_SHIFT;
    endfunction

    assign nobj = (32'(r_object_count) > MAX_OBJECTS) ? OBJCNT_W'(MAX_OBJECTS)
                                                     : r_object_count;

    assign o_req_ready = (r_state == S_IDLE);
    assign req_acc     = i_req_valid && o_req_ready;

    assign q_swap = i_req.start_x > i_req.end_x;
    assign q_x1   = q_swap ? i_req.end_x : i_req.start_x;
    assign q_y1   = q_swap ? i_req.end_y : i_req.start_y;
    assign q_x2   = q_swap ? i_req.start_x : i_req.end_x;
    assign q_y2   = q_swap ? i_req.start_y : i_req.end_y;
    assign q_dx   = q_x2 - q_x1;
    assign q_gen  = q_dx > COORD_W'(NEAR_SPAN);
    assign q_neg  = q_y2 < q_y1;
    assign q_dy   = q_neg ? (q_y1 - q_y2) : (q_y2 - q_y1);

    assign load_we = req_acc && (i_req.req_type == REQ_LOAD)
                     && (32'(i_req.object_index) < MAX_OBJECTS)
                     && (32'(i_req.vertex_index) < MAX_VERTICES);
    assign v_waddr = VADDR_W'(32'(i_req.object_index) * MAX_VERTICES
                              + 32'(i_req.vertex_index));
    assign v_base  = VADDR_W'(32'(r_n) * MAX_VERTICES + 32'(r_m));
    assign v_raddr = (r_state == S_RD0) ? (v_base + VADDR_W'(1)) : v_base;

    soc_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (VDEPTH)
    ) u_vertex_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (v_waddr),
        .i_wdata ({i_req.vertex_x, i_req.vertex_y}),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    soc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_OBJECTS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (OBJ_AW'(i_req.object_index)),
        .i_wdata (i_req.segment_count),
        .i_raddr (OBJ_AW'(r_n)),
        .o_rdata (c_rdata)
    );

    assign e_xb    = v_rdata[2*COORD_W-1:COORD_W];
    assign e_yb    = v_rdata[COORD_W-1:0];
    assign ovl     = (r_hym2 > r_hy1) && (r_hym1 < r_hy2) && (r_xc2 > r_x1) && (r_xc1 < r_x2);
    assign nv_edge = (r_xc2 - r_xc1) <= COORD_W'(NEAR_SPAN);
    assign e_neg   = r_yc2 < r_yc1;
    assign e_dy    = e_neg ? (r_yc1 - r_yc2) : (r_yc2 - r_yc1);

    assign da     = 33'(r_atmp) - 33'(r_a);
    assign db     = 49'(r_b) - 49'(r_btmp);
    assign da_mag = da[32] ? 33'(-da) : 33'(da);
    assign db_mag = db[48] ? 49'(-db) : 49'(db);
    assign nonpar = (r_a != r_atmp) && (r_b != r_btmp) && (da_mag >= 33'(PARALLEL_EPS));

    soc_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_cmd.start),
        .i_num   (div_cmd.num),
        .i_den   (div_cmd.den),
        .o_sts   (div_sts),
        .o_quo   (div_quo)
    );

    assign div_q = r_div_neg ? -$signed(64'(div_quo)) : $signed(64'(div_quo));

    always_comb begin
        div_cmd   = '0;
        n_div_neg = r_div_neg;
        case (r_state)
            S_IDLE: begin
                if (req_acc && (i_req.req_type == REQ_QUERY) && q_gen) begin
                    div_cmd.start = 1'b1;
                    div_cmd.num   = DIV_NUM_W'({q_dy, 16'b0});
                    div_cmd.den   = DIV_DEN_W'(q_dx);
                    n_div_neg     = q_neg;
                end
            end
            S_CLASS: begin
                if (ovl && !nv_edge) begin
                    div_cmd.start = 1'b1;
                    div_cmd.num   = DIV_NUM_W'({e_dy, 16'b0});
                    div_cmd.den   = DIV_DEN_W'(r_xc2 - r_xc1);
                    n_div_neg     = e_neg;
                end
            end
            S_GSEL: begin
                if (r_qgen && nonpar) begin
                    div_cmd.start = 1'b1;
                    div_cmd.num   = DIV_NUM_W'({db_mag, 16'b0});
                    div_cmd.den   = DIV_DEN_W'(da_mag);
                    n_div_neg     = db[48] ^ da[32];
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_QMUL: begin
                mul_a = r_atmp;
                mul_b = $signed({17'b0, r_x1});
            end
            S_CLASS: begin
                mul_a = r_atmp;
                mul_b = $signed({17'b0, r_xc1});
            end
            S_EMUL: begin
                mul_a = r_a;
                mul_b = $signed({17'b0, r_xc1});
            end
            S_GSEL: begin
                mul_a = r_a;
                mul_b = $signed({17'b0, r_x1});
            end
            S_PCHK: begin
                mul_a = r_atmp;
                mul_b = r_px[31:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    assign dvx     = (r_xc1 >= r_xs) ? (r_xc1 - r_xs) : (r_xs - r_xc1);
    assign pyd     = r_py - $signed({19'b0, r_ys, 16'b0});
    assign pyd_mag = pyd[49] ? 50'(-pyd) : 50'(pyd);
    assign pxd     = r_px - $signed({33'b0, r_xs, 16'b0});
    assign pxd_mag = pxd[63] ? 64'(-pxd) : 64'(pxd);
    assign px_hi   = r_px >>> Q_SHIFT;
    assign px_rnd  = (r_px + 64'sd32768) >>> Q_SHIFT;
    assign t1      = trunc_q16(r_prod);
    assign s_q     = 50'(trunc_q16(64'(r_py)));

    always_comb begin
        chk_hit    = 1'b0;
        chk_take_x = 1'b0;
        chk_take_y = 1'b0;
        chk_minpx  = dvx;
        chk_minpy  = pyd_mag[30:16];
        chk_hx     = $signed({1'b0, r_xc1});
        chk_hy     = r_py[31:16];
        case (r_state)
            S_VCHK: begin
                chk_hit = (r_x1 < r_xc1) && (r_x2 > r_xc1)
                          && (r_py > $signed({19'b0, r_hym1, 16'b0}))
                          && (r_py < $signed({19'b0, r_hym2, 16'b0}));
                chk_take_x = dvx < r_minpx;
            end
            S_QCHK: begin
                chk_hit = (r_xc1 < r_x1) && (r_xc2 > r_x1)
                          && (r_py > $signed({19'b0, r_hy1, 16'b0}))
                          && (r_py < $signed({19'b0, r_hy2, 16'b0}));
                chk_take_y = pyd_mag < {19'b0, r_minpy, 16'b0};
                chk_hx     = $signed({1'b0, r_x1});
            end
            S_PCHK: begin
                chk_hit = (r_px > $signed({33'b0, r_x1, 16'b0}))
                          && (r_px < $signed({33'b0, r_x2, 16'b0}))
                          && (px_hi > $signed({49'b0, r_xc1}))
                          && (px_rnd < $signed({49'b0, r_xc2}));
                chk_take_x = pxd_mag < {33'b0, r_minpx, 16'b0};
                chk_minpx  = pxd_mag[30:16];
                chk_hx     = r_px[31:16];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_acc && (i_req.req_type == REQ_QUERY)) begin
                    n_state = q_gen ? S_QDIV : S_OBJ;
                end
            end
            S_QDIV:  if (div_sts.done) n_state = S_QMUL;
            S_QMUL:  n_state = S_QB;
            S_QB:    n_state = S_OBJ;
            S_OBJ:   n_state = (r_n == nobj) ? S_DONE : S_CNT;
            S_CNT:   n_state = S_EDGE;
            S_EDGE:  n_state = (r_m == r_cnt) ? S_OBJ : S_RD0;
            S_RD0:   n_state = S_RD1;
            S_RD1:   n_state = S_CLASS;
            S_CLASS: begin
                if (!ovl) begin
                    n_state = S_NEXT;
                end else if (nv_edge) begin
                    n_state = r_qgen ? S_VPY : S_NEXT;
                end else begin
                    n_state = S_EDIV;
                end
            end
            S_VPY:   n_state = S_VCHK;
            S_VCHK:  n_state = S_NEXT;
            S_EDIV:  if (div_sts.done) n_state = S_EMUL;
            S_EMUL:  n_state = S_EB;
            S_EB:    n_state = S_GSEL;
            S_GSEL: begin
                if (!r_qgen) begin
                    n_state = S_QPY;
                end else begin
                    n_state = nonpar ? S_PDIV : S_NEXT;
                end
            end
            S_QPY:   n_state = S_QCHK;
            S_QCHK:  n_state = S_NEXT;
            S_PDIV:  if (div_sts.done) n_state = S_PCHK;
            S_PCHK:  n_state = (chk_hit && !r_have_first) ? S_HY1 : S_NEXT;
            S_HY1:   n_state = S_HY2;
            S_HY2:   n_state = S_HY3;
            S_HY3:   n_state = S_NEXT;
            S_NEXT:  n_state = S_EDGE;
            S_DONE:  if (!r_rsp_valid || i_rsp_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_object_count <= '0;
            r_rsp_valid    <= 1'b0;
            r_k            <= K_NONE;
            r_have_first   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_object_count <= i_cfg_wdata;
            end
            if ((r_state == S_DONE) && (!r_rsp_valid || i_rsp_ready)) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
            if (req_acc && (i_req.req_type == REQ_QUERY)) begin
                r_k          <= K_NONE;
                r_have_first <= 1'b0;
            end else if (chk_hit) begin
                if (chk_take_x || chk_take_y) begin
                    r_k <= $signed(r_n);
                end
                r_have_first <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_div_neg <= n_div_neg;
        case (r_state)
            S_IDLE: begin
                r_xs    <= i_req.start_x;
                r_ys    <= i_req.start_y;
                r_x1    <= q_x1;
                r_x2    <= q_x2;
                r_y1    <= q_y1;
                r_hy1   <= (i_req.start_y > i_req.end_y) ? i_req.end_y : i_req.start_y;
                r_hy2   <= (i_req.start_y > i_req.end_y) ? i_req.start_y : i_req.end_y;
                r_qgen  <= q_gen;
                r_atmp  <= '0;
                r_btmp  <= '0;
                r_n     <= '0;
                r_minpx <= COORD_W'(FAR_START);
                r_minpy <= COORD_W'(FAR_START);
                r_hits  <= '0;
                r_hx    <= '0;
                r_hy    <= '0;
            end
            S_QDIV: if (div_sts.done) r_atmp <= 32'(div_q);
            S_QB:   r_btmp <= $signed({17'b0, r_y1, 16'b0}) - r_prod[47:0];
            S_CNT: begin
                r_cnt <= (c_rdata > CNT_MAX) ? CNT_MAX : c_rdata;
                r_m   <= '0;
            end
            S_EDGE: if (r_m == r_cnt) r_n <= r_n + OBJCNT_W'(1);
            S_RD0: begin
                r_vx0 <= e_xb;
                r_vy0 <= e_yb;
            end
            S_RD1: begin
                r_hym1 <= (r_vy0 > e_yb) ? e_yb : r_vy0;
                r_hym2 <= (r_vy0 > e_yb) ? r_vy0 : e_yb;
                if (r_vx0 > e_xb) begin
                    r_xc1 <= e_xb;
                    r_yc1 <= e_yb;
                    r_xc2 <= r_vx0;
                    r_yc2 <= r_vy0;
                end else begin
                    r_xc1 <= r_vx0;
                    r_yc1 <= r_vy0;
                    r_xc2 <= e_xb;
                    r_yc2 <= e_yb;
                end
            end
            S_VPY:  r_py <= 50'(r_prod) + 50'(r_btmp);
            S_EDIV: if (div_sts.done) r_a <= 32'(div_q);
            S_EB:   r_b <= $signed({17'b0, r_yc1, 16'b0}) - r_prod[47:0];
            S_QPY:  r_py <= 50'(r_prod) + 50'(r_b);
            S_PDIV: if (div_sts.done) r_px <= div_q;
            S_HY1:  r_py <= 50'(t1);
            S_HY2:  r_py <= r_py + 50'(r_btmp);
            S_HY3: begin
                if (s_q > 50'sd32767) begin
                    r_hy <= 16'sh7fff;
                end else if (s_q < -50'sd32768) begin
                    r_hy <= -16'sh8000;
                end else begin
                    r_hy <= s_q[15:0];
                end
            end
            S_NEXT: r_m <= r_m + CNT_W'(1);
            default: begin
            end
        endcase

        if (chk_hit) begin
            r_hits <= r_hits + HITS_W'(1);
            if (chk_take_x) begin
                r_minpx <= chk_minpx;
            end
            if (chk_take_y) begin
                r_minpy <= chk_minpy;
            end
            if (!r_have_first) begin
                r_hx <= chk_hx;
                if (r_state != S_PCHK) begin
                    r_hy <= chk_hy;
                end
            end
        end

        if ((r_state == S_DONE) && (!r_rsp_valid || i_rsp_ready)) begin
            r_rsp.hit_object  <= r_k;
            r_rsp.hit_count   <= r_hits;
            r_rsp.first_hit_x <= r_hx;
            r_rsp.first_hit_y <= r_hy;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(r_state == S_DONE))
        else $error("result posted outside done state");

    a_nearest_has_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_k != K_NONE) |-> r_have_first)
        else $error("nearest object set without a first crossing");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_cmd.start |-> !div_sts.busy)
        else $error("divider started while busy");

    a_edge_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EDGE) |-> (r_m <= r_cnt))
        else $error("edge counter past edge count");

endmodule
